// ===== src/sphd_pkg.sv =====
package sphd_pkg;

  localparam int unsigned POS_W   = 17;
  localparam int unsigned FIXED_W = 48;
  localparam int unsigned TIME_W  = 64;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [FIXED_W-1:0] fixed_t;

  localparam pos_t FIXED_BYTES = pos_t'(6);
  localparam pos_t POS_MAX     = {POS_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_PAYLOAD   = 2'd1,
    KIND_SHORT_HDR = 2'd2,
    KIND_TRUNCATED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PHASE_IDLE    = 2'd0,
    PHASE_HEADER  = 2'd1,
    PHASE_PAYLOAD = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       buffer_end;
  } item_t;

  typedef struct packed {
    kind_e               kind;
    logic [2:0]          version;
    logic                packet_type;
    logic                secondary_flag;
    logic [10:0]         apid;
    logic [1:0]          sequence_flags;
    logic [13:0]         sequence_count;
    logic [15:0]         length_field;
    logic [TIME_W-1:0]   time_code;
    logic [7:0]          payload_byte;
    pos_t                bytes_used;
    logic                last;
  } result_t;

endpackage

// ===== src/sphd_if.sv =====
interface sphd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output first_byte, output buffer_end,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input buffer_end,
                  output ready);
endinterface

interface sphd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  version;
  logic        packet_type;
  logic        secondary_flag;
  logic [10:0] apid;
  logic [1:0]  sequence_flags;
  logic [13:0] sequence_count;
  logic [15:0] length_field;
  logic [63:0] time_code;
  logic [7:0]  payload_byte;
  logic [16:0] bytes_used;
  logic        last;

  modport source (output valid, output kind, output version, output packet_type,
                  output secondary_flag, output apid, output sequence_flags,
                  output sequence_count, output length_field, output time_code,
                  output payload_byte, output bytes_used, output last,
                  input ready);
  modport sink   (input valid, input kind, input version, input packet_type,
                  input secondary_flag, input apid, input sequence_flags,
                  input sequence_count, input length_field, input time_code,
                  input payload_byte, input bytes_used, input last,
                  output ready);
endinterface

// ===== src/sphd_in_reg.sv =====
module sphd_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  sphd_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            advance_i,
  output sphd_pkg::item_t item_o
);

  logic            valid_q;
  sphd_pkg::item_t item_q;

  // Take a new byte when empty or when the held one moves on this cycle.
  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== src/sphd_engine.sv =====
module sphd_engine #(
  parameter int unsigned HEADER_BYTES = 14,
  parameter int unsigned TIME_BITS    = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              proc_i,
  input  sphd_pkg::item_t   item_i,
  input  logic              res_ready_i,
  output logic              res_valid_o,
  output sphd_pkg::result_t res_o
);

  localparam sphd_pkg::pos_t HDR_POS = sphd_pkg::pos_t'(HEADER_BYTES);

  sphd_pkg::phase_e  phase_q, phase_d;
  sphd_pkg::pos_t    pos_q, pos_d;
  sphd_pkg::fixed_t  fixed_q, fixed_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [15:0]       rem_q, rem_d;

  sphd_pkg::phase_e  eff_phase;
  sphd_pkg::pos_t    eff_pos;
  sphd_pkg::fixed_t  eff_fixed;
  logic [TIME_BITS-1:0] eff_time;
  logic [15:0]       eff_rem;
  sphd_pkg::pos_t    pos_new;
  sphd_pkg::fixed_t  fixed_new;
  logic [TIME_BITS-1:0] time_new;
  logic [15:0]       rem_dec;

  logic              has_res;
  sphd_pkg::result_t res;
  logic              res_valid_q;
  sphd_pkg::result_t res_q;

  function automatic sphd_pkg::result_t with_header(sphd_pkg::result_t r,
                                                    sphd_pkg::fixed_t f,
                                                    logic [TIME_BITS-1:0] t);
    sphd_pkg::result_t o;
    o                = r;
    o.version        = f[47:45];
    o.packet_type    = f[44];
    o.secondary_flag = f[43];
    o.apid           = f[42:32];
    o.sequence_flags = f[31:30];
    o.sequence_count = f[29:16];
    o.length_field   = f[15:0];
    o.time_code      = sphd_pkg::TIME_W'(t);
    return o;
  endfunction

  always_comb begin
    // A first byte restarts the packet whatever the phase.
    eff_phase = item_i.first_byte ? sphd_pkg::PHASE_HEADER : phase_q;
    eff_pos   = item_i.first_byte ? '0 : pos_q;
    eff_fixed = item_i.first_byte ? '0 : fixed_q;
    eff_time  = item_i.first_byte ? '0 : time_q;
    eff_rem   = item_i.first_byte ? '0 : rem_q;

    phase_d = eff_phase;
    pos_d   = eff_pos;
    fixed_d = eff_fixed;
    time_d  = eff_time;
    rem_d   = eff_rem;
    pos_new   = eff_pos + sphd_pkg::pos_t'(1);
    fixed_new = eff_fixed;
    time_new  = eff_time;
    rem_dec   = (eff_rem != 16'd0) ? eff_rem - 16'd1 : eff_rem;
    has_res   = 1'b0;
    res       = '0;

    case (eff_phase)
      sphd_pkg::PHASE_HEADER: begin
        if (pos_new <= sphd_pkg::FIXED_BYTES) begin
          fixed_new = {eff_fixed[sphd_pkg::FIXED_W-9:0], item_i.data_byte};
        end else begin
          time_new = TIME_BITS'({eff_time, item_i.data_byte});
        end
        pos_d   = pos_new;
        fixed_d = fixed_new;
        time_d  = time_new;
        if (pos_new >= HDR_POS) begin
          has_res = 1'b1;
          rem_d   = fixed_new[15:0];
          res     = with_header(res, fixed_new, time_new);
          res.kind = sphd_pkg::KIND_HEADER;
          phase_d = sphd_pkg::PHASE_PAYLOAD;
          if (fixed_new[31]) begin
            if (item_i.buffer_end) begin
              res.last       = 1'b1;
              res.bytes_used = pos_new;
              phase_d        = sphd_pkg::PHASE_IDLE;
            end
          end else if (fixed_new[15:0] == 16'd0 || item_i.buffer_end) begin
            if (fixed_new[15:0] != 16'd0) begin
              res.kind = sphd_pkg::KIND_TRUNCATED;
            end
            res.last       = 1'b1;
            res.bytes_used = pos_new;
            phase_d        = sphd_pkg::PHASE_IDLE;
          end
        end else if (item_i.buffer_end) begin
          has_res        = 1'b1;
          res.kind       = sphd_pkg::KIND_SHORT_HDR;
          res.last       = 1'b1;
          res.bytes_used = pos_new;
          phase_d        = sphd_pkg::PHASE_IDLE;
        end
      end
      sphd_pkg::PHASE_PAYLOAD: begin
        pos_new      = (eff_pos < sphd_pkg::POS_MAX) ? pos_new : eff_pos;
        pos_d        = pos_new;
        has_res      = 1'b1;
        res          = with_header(res, eff_fixed, eff_time);
        res.kind     = sphd_pkg::KIND_PAYLOAD;
        res.payload_byte = item_i.data_byte;
        if (eff_fixed[31]) begin
          if (item_i.buffer_end) begin
            res.last       = 1'b1;
            res.bytes_used = pos_new;
            phase_d        = sphd_pkg::PHASE_IDLE;
          end
        end else begin
          rem_d = rem_dec;
          if (rem_dec == 16'd0 || item_i.buffer_end) begin
            if (rem_dec != 16'd0) begin
              res.kind = sphd_pkg::KIND_TRUNCATED;
            end
            res.last       = 1'b1;
            res.bytes_used = pos_new;
            phase_d        = sphd_pkg::PHASE_IDLE;
          end
        end
      end
      default: begin
        phase_d = eff_phase;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sphd_pkg::PHASE_IDLE;
      pos_q   <= '0;
      fixed_q <= '0;
      time_q  <= '0;
      rem_q   <= '0;
    end else if (proc_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      fixed_q <= fixed_d;
      time_q  <= time_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (proc_i) begin
      res_valid_q <= has_res;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_i && has_res) begin
      res_q <= res;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  a_last_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && has_res && res.last |=> phase_q == sphd_pkg::PHASE_IDLE)
    else $error("phase not idle after final result");

  a_header_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == sphd_pkg::PHASE_HEADER |-> pos_q < HDR_POS)
    else $error("header position ran past header length");

  a_counted_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == sphd_pkg::PHASE_PAYLOAD && !fixed_q[31] |-> rem_q != 16'd0)
    else $error("counted payload open with nothing remaining");

  a_short_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.kind == sphd_pkg::KIND_SHORT_HDR
      |-> res_q.last && res_q.bytes_used < HDR_POS)
    else $error("short header result malformed");
`endif

endmodule

// ===== src/space_packet_header_deframer_core.sv =====
// Path: the transfer loads the input register, and the result register loads when
// the held byte advances, which waits while an unaccepted result is held.
// Throughput: one byte per cycle while the result channel is not stalled; the
// single-pass state update on each byte sets that figure. Bytes that close
// nothing (idle bytes, header bytes before the last) produce no result.
// Reset: rst_ni is asynchronous, active low; it clears the parser state and
// both valid flags. No clearing pass; the block is ready right after reset.
module space_packet_header_deframer_core #(
  parameter int unsigned HEADER_BYTES = 14,
  parameter int unsigned TIME_BITS    = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sphd_in_if.sink    in_i,
  sphd_out_if.source out_o
);

  sphd_pkg::item_t   in_item;
  sphd_pkg::item_t   held_item;
  logic              held_valid;
  logic              advance;
  logic              res_valid;
  sphd_pkg::result_t res;

  // Pack the incoming transfer fields for the input register.
  assign in_item.data_byte  = in_i.data_byte;
  assign in_item.first_byte = in_i.first_byte;
  assign in_item.buffer_end = in_i.buffer_end;

  // Advance the held byte when the result register is free or being drained.
  // This lets a new byte enter while a finished result still waits.
  assign advance = held_valid && (!res_valid || out_o.ready);

  sphd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .ready_o   (in_i.ready),
    .item_i    (in_item),
    .valid_o   (held_valid),
    .advance_i (advance),
    .item_o    (held_item)
  );

  // Parser state and the result register; one byte processed per advance.
  sphd_engine #(
    .HEADER_BYTES (HEADER_BYTES),
    .TIME_BITS    (TIME_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_i      (advance),
    .item_i      (held_item),
    .res_ready_i (out_o.ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Drive the result channel straight from the result register.
  assign out_o.valid          = res_valid;
  assign out_o.kind           = res.kind;
  assign out_o.version        = res.version;
  assign out_o.packet_type    = res.packet_type;
  assign out_o.secondary_flag = res.secondary_flag;
  assign out_o.apid           = res.apid;
  assign out_o.sequence_flags = res.sequence_flags;
  assign out_o.sequence_count = res.sequence_count;
  assign out_o.length_field   = res.length_field;
  assign out_o.time_code      = res.time_code;
  assign out_o.payload_byte   = res.payload_byte;
  assign out_o.bytes_used     = res.bytes_used;
  assign out_o.last           = res.last;

endmodule
